FILE: src/apc_pkg.sv
// Package: shared types and codes of the allocation pairing checker.
package apc_pkg;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    K_WRONG_SIZE  = 3'd0,
    K_WRONG_KIND  = 3'd1,
    K_NO_ALLOC    = 3'd2,
    K_UNFREED     = 3'd3,
    K_TABLE_FULL  = 3'd4,
    K_FLUSH_EMPTY = 3'd5
  } report_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_READ,
    S_CHECK,
    S_KIND,
    S_SHIFT,
    S_FLUSH_RD,
    S_FLUSH_EMIT,
    S_EMIT_WAIT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic         latch_req;
    logic         write_tail;
    logic         dec_count;
    logic         clr_count;
    logic         search_start;
    logic         search_step;
    logic         rd_hit;
    logic         rd_ptr;
    logic         ptr_inc;
    logic         shift_step;
    logic         emit;
    report_kind_t emit_kind;
    logic         emit_last;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    req_type_t req_type;
    logic      full;
    logic      empty;
    logic      search_done;
    logic      hit;
    logic      size_diff;
    logic      kind_diff;
    logic      ptr_last;
    logic      shift_done;
    logic      out_busy;
  } status_t;

endpackage

FILE: src/apc_if.sv
// Interfaces: valid/ready channels for events and reports.
interface apc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        is_vec;
  logic [31:0] address;
  logic [31:0] size;
  logic [31:0] caller;
  logic [7:0]  process_id;
  logic [31:0] line_number;
  modport source(output valid, req_type, is_vec, address, size, caller, process_id,
                 line_number, input ready);
  modport sink(input valid, req_type, is_vec, address, size, caller, process_id,
               line_number, output ready);
endinterface

interface apc_rpt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  report_kind;
  logic        last;
  logic        stored_is_vec;
  logic [31:0] stored_address;
  logic [31:0] stored_size;
  logic [31:0] stored_caller;
  logic [7:0]  stored_process;
  logic [31:0] stored_line;
  logic [31:0] given_size;
  logic        given_is_vec;
  logic [7:0]  given_process;
  logic [31:0] given_line;
  modport source(output valid, report_kind, last, stored_is_vec, stored_address,
                 stored_size, stored_caller, stored_process, stored_line, given_size,
                 given_is_vec, given_process, given_line, input ready);
  modport sink(input valid, report_kind, last, stored_is_vec, stored_address,
               stored_size, stored_caller, stored_process, stored_line, given_size,
               given_is_vec, given_process, given_line, output ready);
endinterface

FILE: src/apc_ctrl.sv
// Controller: sequences alloc, free search/shift and flush over the table.
module apc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  apc_pkg::status_t st,
  output apc_pkg::cmd_t    cmd
);
  apc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= apc_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.emit_kind = apc_pkg::K_WRONG_SIZE;
    in_ready      = 1'b0;
    unique case (state)
      apc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = apc_pkg::S_DECIDE;
        end
      end
      apc_pkg::S_DECIDE: begin
        if (!st.out_busy) begin
          unique case (st.req_type)
            apc_pkg::REQ_ALLOC: begin
              if (st.full) begin
                cmd.emit = 1'b1; cmd.emit_kind = apc_pkg::K_TABLE_FULL;
                cmd.emit_last = 1'b1;
              end else begin
                cmd.write_tail = 1'b1;
              end
              state_next = apc_pkg::S_IDLE;
            end
            apc_pkg::REQ_FREE: begin
              cmd.search_start = 1'b1;
              state_next = apc_pkg::S_SEARCH;
            end
            apc_pkg::REQ_FLUSH: begin
              if (st.empty) begin
                cmd.emit = 1'b1; cmd.emit_kind = apc_pkg::K_FLUSH_EMPTY;
                cmd.emit_last = 1'b1;
                state_next = apc_pkg::S_IDLE;
              end else begin
                cmd.rd_ptr = 1'b1;
                state_next = apc_pkg::S_FLUSH_EMIT;
              end
            end
            default: state_next = apc_pkg::S_IDLE;
          endcase
        end
      end
      apc_pkg::S_SEARCH: begin
        if (st.hit) begin
          cmd.rd_hit = 1'b1;
          state_next = apc_pkg::S_CHECK;
        end else if (st.search_done) begin
          cmd.emit = 1'b1; cmd.emit_kind = apc_pkg::K_NO_ALLOC;
          cmd.emit_last = 1'b1;
          state_next = apc_pkg::S_IDLE;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      apc_pkg::S_CHECK: begin
        if (!st.out_busy) begin
          if (st.size_diff) begin
            cmd.emit = 1'b1; cmd.emit_kind = apc_pkg::K_WRONG_SIZE;
            cmd.emit_last = !st.kind_diff;
          end
          state_next = apc_pkg::S_KIND;
        end
      end
      apc_pkg::S_KIND: begin
        if (!st.out_busy) begin
          if (st.kind_diff) begin
            cmd.emit = 1'b1; cmd.emit_kind = apc_pkg::K_WRONG_KIND;
            cmd.emit_last = 1'b1;
          end
          state_next = apc_pkg::S_SHIFT;
        end
      end
      apc_pkg::S_SHIFT: begin
        if (st.shift_done) begin
          cmd.dec_count = 1'b1;
          state_next = apc_pkg::S_IDLE;
        end else begin
          cmd.shift_step = 1'b1;
          state_next = apc_pkg::S_READ;
        end
      end
      apc_pkg::S_READ: state_next = apc_pkg::S_SHIFT;
      apc_pkg::S_FLUSH_RD: begin
        cmd.rd_ptr = 1'b1;
        state_next = apc_pkg::S_FLUSH_EMIT;
      end
      apc_pkg::S_FLUSH_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit = 1'b1; cmd.emit_kind = apc_pkg::K_UNFREED;
          cmd.emit_last = st.ptr_last;
          if (st.ptr_last) begin
            cmd.clr_count = 1'b1;
            state_next = apc_pkg::S_IDLE;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_next = apc_pkg::S_FLUSH_RD;
          end
        end
      end
      default: state_next = apc_pkg::S_IDLE;
    endcase
  end
endmodule

FILE: src/apc_dp.sv
// Datapath: entry memory, count, search pointer and report register.
module apc_dp #(
  parameter int DEPTH        = 64,
  parameter int NAME_ID_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  apc_req_if.sink       req,
  apc_rpt_if.source     rpt,
  input  apc_pkg::cmd_t cmd,
  output apc_pkg::status_t st
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 1 + 32 + 32 + 32 + NAME_ID_BITS + 32;

  typedef struct packed {
    logic                    is_vec;
    logic [31:0]             address;
    logic [31:0]             size;
    logic [31:0]             caller;
    logic [NAME_ID_BITS-1:0] process;
    logic [31:0]             line;
  } rec_t;

  logic [EW-1:0] mem [DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;       // one above the entry being searched or moved, or walk index
  rec_t          rq;
  logic [1:0]    rq_type;
  rec_t          rd;
  logic [31:0]   rd_addr;
  logic          rd_addr_ok;
  logic          ptr_at_top;
  logic          shift_at_end;

  assign ptr_at_top   = (ptr + CW'(1) >= count);
  assign shift_at_end = (ptr >= count);

  // Request register and entry count.
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      rq_type    <= req.req_type;
      rq.is_vec  <= req.is_vec;
      rq.address <= req.address;
      rq.size    <= req.size;
      rq.caller  <= req.caller;
      rq.process <= NAME_ID_BITS'(req.process_id);
      rq.line    <= req.line_number;
    end
    if (rst) begin
      count <= '0;
    end else if (cmd.write_tail) begin
      count <= count + CW'(1);
    end else if (cmd.dec_count) begin
      count <= count - CW'(1);
    end else if (cmd.clr_count) begin
      count <= '0;
    end
  end

  // Pointer: search counts down from count; walk and compaction count up.
  always_ff @(posedge clk) begin
    if (cmd.search_start)       ptr <= count;
    else if (cmd.search_step)   ptr <= ptr - CW'(1);
    else if (cmd.shift_step)    ptr <= ptr + CW'(1);
    else if (cmd.ptr_inc)       ptr <= ptr + CW'(1);
    else if (cmd.latch_req)     ptr <= '0;
  end

  // Memory: one write port, one read port with registered data.
  logic [AW-1:0] raddr;
  logic          rvalid_addr;
  always_comb begin
    raddr = ptr[AW-1:0];
    if (cmd.search_start) raddr = AW'(count - CW'(1));
    if (cmd.search_step)  raddr = AW'(ptr - CW'(2));
    if (cmd.shift_step)   raddr = AW'(ptr + CW'(1));
    rvalid_addr = 1'b1;
  end

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  always_comb begin
    we    = cmd.write_tail || cmd.shift_step;
    waddr = cmd.write_tail ? count[AW-1:0] : AW'(ptr - CW'(1));
    wdata = cmd.write_tail ? EW'(rq) : EW'(rd);
  end

  logic [EW-1:0] rdata;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rvalid_addr) rdata <= mem[raddr];
  end

  // Search: compare the registered read against the request address.
  logic srch_valid;
  always_ff @(posedge clk) begin
    if (rst) srch_valid <= 1'b0;
    else     srch_valid <= cmd.search_start || cmd.search_step;
  end
  assign rd = rec_t'(rdata);
  assign rd_addr = rd.address;
  assign rd_addr_ok = srch_valid && (ptr != '0) && (rd_addr == rq.address);

  // Held copy of the matched or walked entry for reporting.
  rec_t hold;
  always_ff @(posedge clk) begin
    if (cmd.rd_hit || cmd.emit_kind == apc_pkg::K_UNFREED) hold <= rd;
  end
  rec_t cur;
  assign cur = cmd.rd_hit ? rd : hold;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt.valid <= 1'b0;
    end else if (cmd.emit) begin
      rpt.valid <= 1'b1;
    end else if (rpt.ready) begin
      rpt.valid <= 1'b0;
    end
    if (cmd.emit) begin
      rpt.report_kind <= cmd.emit_kind;
      rpt.last        <= cmd.emit_last;
      rpt.given_size    <= '0;
      rpt.given_is_vec  <= 1'b0;
      rpt.given_process <= '0;
      rpt.given_line    <= '0;
      unique case (cmd.emit_kind)
        apc_pkg::K_WRONG_SIZE, apc_pkg::K_WRONG_KIND: begin
          rpt.stored_is_vec  <= hold.is_vec;
          rpt.stored_address <= hold.address;
          rpt.stored_size    <= hold.size;
          rpt.stored_caller  <= hold.caller;
          rpt.stored_process <= 8'(hold.process);
          rpt.stored_line    <= hold.line;
          rpt.given_size     <= rq.size;
          rpt.given_is_vec   <= rq.is_vec;
          rpt.given_process  <= 8'(rq.process);
          rpt.given_line     <= rq.line;
        end
        apc_pkg::K_UNFREED: begin
          rpt.stored_is_vec  <= rd.is_vec;
          rpt.stored_address <= rd.address;
          rpt.stored_size    <= rd.size;
          rpt.stored_caller  <= rd.caller;
          rpt.stored_process <= 8'(rd.process);
          rpt.stored_line    <= rd.line;
        end
        apc_pkg::K_FLUSH_EMPTY: begin
          rpt.stored_is_vec  <= 1'b0;
          rpt.stored_address <= '0;
          rpt.stored_size    <= '0;
          rpt.stored_caller  <= '0;
          rpt.stored_process <= '0;
          rpt.stored_line    <= '0;
        end
        default: begin
          rpt.stored_is_vec  <= rq.is_vec;
          rpt.stored_address <= rq.address;
          rpt.stored_size    <= rq.size;
          rpt.stored_caller  <= rq.caller;
          rpt.stored_process <= 8'(rq.process);
          rpt.stored_line    <= rq.line;
        end
      endcase
    end
  end

  always_comb begin
    st.req_type    = apc_pkg::req_type_t'(rq_type);
    st.full        = (count == CW'(DEPTH));
    st.empty       = (count == '0);
    st.hit         = rd_addr_ok;
    st.search_done = (ptr == '0);
    st.size_diff   = (cur.size != rq.size);
    st.kind_diff   = (cur.is_vec != rq.is_vec);
    st.ptr_last    = ptr_at_top;
    st.shift_done  = shift_at_end;
    st.out_busy    = rpt.valid && !rpt.ready;
  end
endmodule

FILE: src/allocation_pairing_checker.sv
// Top level: allocation pairing checker.
//
// Usage:
//   req  - sink channel of parsed trace events (alloc, free, flush).
//   rpt  - source channel of reports; last marks the final report of an event.
//   An event is taken only when the block is idle; ready is high then.
//   What each event does:
//     alloc  : writes the entry at the tail; on a full table a report is loaded.
//     free   : search walks the table newest first, one entry a cycle
//              through the single read port, then compacts the entries
//              above the hit, moving each down by one place; a miss loads
//              a report instead.
//     flush  : one report when empty, else one per entry, read through the read port.
//   Reports leave through one output register; a stalled receiver holds the
//   register and the controller waits before issuing the next report.
//   Reset clears the entry count and the controller; the table contents are
//   left as they were and are never used above the count.
module allocation_pairing_checker #(
  parameter int DEPTH        = 64,
  parameter int NAME_ID_BITS = 8
) (
  input logic       clk,
  input logic       rst,
  apc_req_if.sink   req,
  apc_rpt_if.source rpt
);
  apc_pkg::cmd_t    cmd;
  apc_pkg::status_t st;

  // Sequence the event.
  apc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .st(st), .cmd(cmd)
  );

  // Hold the table and drive the reports.
  apc_dp #(.DEPTH(DEPTH), .NAME_ID_BITS(NAME_ID_BITS)) u_dp (
    .clk(clk), .rst(rst), .req(req), .rpt(rpt), .cmd(cmd), .st(st)
  );
endmodule

FILE: src/apc_checker.sv
// Checker: port-level assertions on the pairing checker.
module apc_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rpt_valid,
  input logic       rpt_ready,
  input logic       rpt_last,
  input logic [2:0] rpt_kind
);
  a_kind: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> (rpt_kind <= apc_pkg::K_FLUSH_EMPTY)) else $error("bad report kind");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && !rpt_ready |=> rpt_valid) else $error("report dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("accepted twice");
  a_lastk: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && (rpt_kind == apc_pkg::K_NO_ALLOC || rpt_kind == apc_pkg::K_TABLE_FULL ||
                  rpt_kind == apc_pkg::K_FLUSH_EMPTY) |-> rpt_last)
    else $error("single report not last");
endmodule

bind allocation_pairing_checker apc_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rpt_valid(rpt.valid), .rpt_ready(rpt.ready), .rpt_last(rpt.last),
  .rpt_kind(rpt.report_kind)
);

FILE: tb/sv/allocation_pairing_checker_tb.sv
// Testbench: allocation pairing checker, scoreboarded against a behavioural table.
`timescale 1ns / 100ps

module allocation_pairing_checker_tb;

  localparam int DEPTH = 64;

  // One trace event as driven on the request channel.
  typedef struct {
    logic [1:0]  kind;
    logic        vec;
    logic [31:0] addr;
    logic [31:0] bytes;
    logic [31:0] origin;
    logic [7:0]  pid;
    logic [31:0] lineno;
  } event_t;

  // One report as it should appear on the report channel.
  typedef struct packed {
    logic [2:0]  rkind;
    logic        last;
    logic        s_vec;
    logic [31:0] s_addr;
    logic [31:0] s_size;
    logic [31:0] s_caller;
    logic [7:0]  s_pid;
    logic [31:0] s_line;
    logic [31:0] g_size;
    logic        g_vec;
    logic [7:0]  g_pid;
    logic [31:0] g_line;
  } report_t;

  // Directed row: an event, plus an optional typed-in first report.
  typedef struct {
    event_t  ev;
    bit      has_fixed;
    report_t fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  apc_req_if req ();
  apc_rpt_if rpt ();

  allocation_pairing_checker #(.DEPTH(DEPTH), .NAME_ID_BITS(8)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rpt(rpt)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the allocation table, held oldest first.
  event_t  live_allocs[$];
  report_t pending_reports[$];
  int      errors = 0;
  int      events_sent = 0;
  int      reports_seen = 0;
  int      kinds_seen[6];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  function automatic report_t make_report(apc_pkg::report_kind_t k, event_t s,
                                          bit with_given, event_t g);
    report_t r;
    r = '0;
    r.rkind    = k;
    r.s_vec    = s.vec;
    r.s_addr   = s.addr;
    r.s_size   = s.bytes;
    r.s_caller = s.origin;
    r.s_pid    = s.pid;
    r.s_line   = s.lineno;
    if (with_given) begin
      r.g_size = g.bytes;
      r.g_vec  = g.vec;
      r.g_pid  = g.pid;
      r.g_line = g.lineno;
    end
    return r;
  endfunction

  // Advance the shadow table by one event and queue the reports it causes.
  function automatic void predict_reports(event_t e);
    report_t out[$];
    event_t  zero_ev;
    int      hit;
    zero_ev = '{default: '0};
    hit = -1;
    case (e.kind)
      apc_pkg::REQ_ALLOC: begin
        if (live_allocs.size() >= DEPTH)
          out.push_back(make_report(apc_pkg::K_TABLE_FULL, e, 0, e));
        else live_allocs.push_back(e);
      end
      apc_pkg::REQ_FREE: begin
        // search newest first
        for (int i = live_allocs.size() - 1; i >= 0; i--) begin
          if (live_allocs[i].addr == e.addr) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          out.push_back(make_report(apc_pkg::K_NO_ALLOC, e, 0, e));
        end else begin
          if (live_allocs[hit].bytes != e.bytes)
            out.push_back(make_report(apc_pkg::K_WRONG_SIZE, live_allocs[hit], 1, e));
          if (live_allocs[hit].vec != e.vec)
            out.push_back(make_report(apc_pkg::K_WRONG_KIND, live_allocs[hit], 1, e));
          live_allocs.delete(hit);
        end
      end
      apc_pkg::REQ_FLUSH: begin
        if (live_allocs.size() == 0)
          out.push_back(make_report(apc_pkg::K_FLUSH_EMPTY, zero_ev, 0, e));
        foreach (live_allocs[i])
          out.push_back(make_report(apc_pkg::K_UNFREED, live_allocs[i], 0, e));
        live_allocs.delete();
      end
      default: ;  // unused type: ignored
    endcase
    if (out.size() > 0) out[out.size() - 1].last = 1'b1;
    foreach (out[i]) pending_reports.push_back(out[i]);
  endfunction

  function automatic event_t mk(logic [1:0] k, logic v, logic [31:0] a, logic [31:0] b,
                                logic [31:0] c, logic [7:0] p, logic [31:0] l);
    event_t e;
    e = '{kind: k, vec: v, addr: a, bytes: b, origin: c, pid: p, lineno: l};
    return e;
  endfunction

  function automatic event_t rand_event(int pct_alloc, int pct_free, bit reuse);
    event_t e;
    int     r;
    r = $urandom_range(99);
    e.vec    = 1'($urandom_range(1));
    e.addr   = $urandom();
    e.bytes  = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(256);
    e.origin = $urandom();
    e.pid    = 8'($urandom_range(255));
    e.lineno = $urandom();
    if (r < pct_alloc) e.kind = apc_pkg::REQ_ALLOC;
    else if (r < pct_alloc + pct_free) e.kind = apc_pkg::REQ_FREE;
    else if (r < 98) e.kind = apc_pkg::REQ_FLUSH;
    else e.kind = apc_pkg::REQ_NONE;
    // most frees pair with a live entry, usually with matching size and kind
    if (e.kind == apc_pkg::REQ_FREE && reuse && live_allocs.size() > 0 &&
        $urandom_range(9) < 8) begin
      event_t src;
      src = live_allocs[$urandom_range(live_allocs.size() - 1)];
      e.addr = src.addr;
      if ($urandom_range(3) != 0) e.bytes = src.bytes;
      if ($urandom_range(3) != 0) e.vec = src.vec;
    end
    // a narrow address pool now and then, so duplicates exist in the table
    if (e.kind == apc_pkg::REQ_ALLOC && $urandom_range(7) == 0) e.addr = $urandom_range(3);
    return e;
  endfunction

  // Drive one event at the falling edge and hold it until accepted.
  task automatic send_event(event_t e);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid       <= 1'b1;
    req.req_type    <= e.kind;
    req.is_vec      <= e.vec;
    req.address     <= e.addr;
    req.size        <= e.bytes;
    req.caller      <= e.origin;
    req.process_id  <= e.pid;
    req.line_number <= e.lineno;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_reports(e);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Receiver: toggle ready at the falling edge, compare at the rising edge.
  always @(negedge clk) begin
    if (rst) rpt.ready <= 1'b0;
    else rpt.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    report_t got, want;
    if (!rst && rpt.valid && rpt.ready) begin
      got = '{rpt.report_kind, rpt.last, rpt.stored_is_vec, rpt.stored_address,
              rpt.stored_size, rpt.stored_caller, rpt.stored_process, rpt.stored_line,
              rpt.given_size, rpt.given_is_vec, rpt.given_process, rpt.given_line};
      reports_seen++;
      if (got.rkind < 6) kinds_seen[got.rkind]++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, got %h", $time, got);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          $display("%0t: report mismatch, expected %h got %h", $time, want, got);
          if (got.rkind !== want.rkind)
            $display("%0t:   kind expected %0d got %0d", $time, want.rkind, got.rkind);
          errors++;
        end
      end
    end
  end

  row_t    rows[$];
  report_t fx;

  initial begin
    req.valid = 1'b0;
    req.req_type = apc_pkg::REQ_NONE;
    req.is_vec = 1'b0;
    req.address = '0;
    req.size = '0;
    req.caller = '0;
    req.process_id = '0;
    req.line_number = '0;

    // Directed table. Fixed reports are typed in only where obvious.
    fx = '0; fx.rkind = apc_pkg::K_FLUSH_EMPTY; fx.last = 1'b1;
    rows.push_back('{mk(apc_pkg::REQ_FLUSH, 1, '1, '1, '1, 8'hFF, '1), 1, fx});
    rows.push_back('{mk(apc_pkg::REQ_NONE, 1, 32'h5, 32'h5, 0, 0, 1), 0, fx});
    fx = '0; fx.rkind = apc_pkg::K_NO_ALLOC; fx.last = 1'b1; fx.s_vec = 1; fx.s_addr = '1;
    fx.s_size = '1; fx.s_caller = '1; fx.s_pid = 8'hFF; fx.s_line = '1;
    rows.push_back('{mk(apc_pkg::REQ_FREE, 1, '1, '1, '1, 8'hFF, '1), 1, fx});
    rows.push_back('{mk(apc_pkg::REQ_ALLOC, 0, '1, 32'h10, 32'h1234, 8'h01, 2), 0, fx});
    rows.push_back('{mk(apc_pkg::REQ_ALLOC, 1, 32'h0, '1, '1, 8'hFF, 3), 0, fx});
    rows.push_back('{mk(apc_pkg::REQ_ALLOC, 0, 32'h0, 32'h0, 32'h0, 8'h00, 4), 0, fx});
    // newest, clean
    rows.push_back('{mk(apc_pkg::REQ_FREE, 0, 32'h0, 32'h0, 32'h9, 8'h02, 5), 0, fx});
    // size and kind
    rows.push_back('{mk(apc_pkg::REQ_FREE, 0, 32'h0, 32'h7, 32'h9, 8'h03, 6), 0, fx});
    // kind only
    rows.push_back('{mk(apc_pkg::REQ_FREE, 1, '1, 32'h10, 32'h0, 8'hAA, 7), 0, fx});
    rows.push_back('{mk(apc_pkg::REQ_ALLOC, 0, 32'hA5A5A5A5, 32'h8, 32'h1, 8'h55, 8), 0, fx});
    // size only
    rows.push_back('{mk(apc_pkg::REQ_FREE, 0, 32'hA5A5A5A5, 32'h9, 32'h1, 8'h55, 9), 0, fx});
    rows.push_back('{mk(apc_pkg::REQ_ALLOC, 1, 32'h100, 32'h20, 32'h2, 8'h10, 10), 0, fx});
    rows.push_back('{mk(apc_pkg::REQ_ALLOC, 0, 32'h200, 32'h30, 32'h3, 8'h20, 11), 0, fx});
    rows.push_back('{mk(apc_pkg::REQ_ALLOC, 1, 32'h300, 32'h40, 32'h4, 8'h30, 12), 0, fx});
    // middle
    rows.push_back('{mk(apc_pkg::REQ_FREE, 0, 32'h200, 32'h30, 32'h3, 8'h20, 13), 0, fx});
    // unfreed
    rows.push_back('{mk(apc_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, 14), 0, fx});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      send_event(rows[i].ev);
      if (rows[i].has_fixed && pending_reports.size() > 0 &&
          pending_reports[0] !== rows[i].fixed) begin
        $display("%0t: directed row %0d, expected %h predicted %h", $time, i,
                 rows[i].fixed, pending_reports[0]);
        errors++;
      end
    end

    // Fill the table to the brim, overflow it, then flush every entry.
    for (int i = 0; i < DEPTH + 2; i++)
      send_event(mk(apc_pkg::REQ_ALLOC, i[0], 32'(i), 32'(i), 32'(i), 8'(i), 32'(i)));
    send_event(mk(apc_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, 0));
    wait_drained();  // sender holds off until every report has come

    // Random phases: receiver idle, then sender idle, then neither.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 12 : 0;
      for (int n = 0; n < 115; n++) begin
        if (ph == 2 && n < 60) send_event(rand_event(70, 28, 1));  // push towards full
        else send_event(rand_event(50, 45, n % 10 != 0));
      end
      send_event(mk(apc_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, 0));
      wait_drained();
    end

    $display("events sent %0d, reports checked %0d", events_sent, reports_seen);
    $display("report kinds size/kind/noalloc/unfreed/full/empty: %0d %0d %0d %0d %0d %0d",
             kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3], kinds_seen[4],
             kinds_seen[5]);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule
